### rtl/core/bmhq_pkg.sv
// bmhq_pkg: shared types and codes for the binary max-heap queue
// holds the transfer structs, heap entry type, mode and status codes
// no dependencies
`default_nettype none

package bmhq_pkg;

  localparam int unsigned HEAP_DEPTH = 256;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned TAG_W   = 12;
  localparam int unsigned COUNT_W = 9;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_POP   = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] item_key;
    logic [TAG_W-1:0] item_tag;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   out_key;
    logic [TAG_W-1:0]   out_tag;
    logic [COUNT_W-1:0] entry_count;
  } out_t;

endpackage

`default_nettype wire

### rtl/core/bmhq_ram.sv
// bmhq_ram: heap entry storage, one write port and two registered read ports
// depends on bmhq_pkg for the entry type
`default_nettype none

module bmhq_ram import bmhq_pkg::*; #(
  parameter int unsigned DEPTH = HEAP_DEPTH,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire entry_t        wdata_i,
  input  wire logic [AW-1:0] raddr0_i,
  input  wire logic [AW-1:0] raddr1_i,
  output entry_t             rdata0_o,
  output entry_t             rdata1_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata0_q;
  entry_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

`default_nettype wire

### rtl/core/binary_max_heap_queue.sv
// binary_max_heap_queue: max-heap priority queue of (key, tag) entries
// sequencer walks the heap one level per step around a shared compare unit
// depends on bmhq_pkg and bmhq_ram
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i
//   out     | output    | out_valid_o / out_stall_i  | out_data_o
//
// one item at a time: clear, refused push and empty pop/peek go straight to
// the finish state; peek reads the root; push climbs from the new last slot
// while its parent's key is smaller; pop reads the root and the last entry,
// which sinks unless the heap is left empty; each level is one memory read
// and one compare/write. reset empties the heap, entries need no clearing.
// a finished result waits in the output register while the next item enters.
`default_nettype none

module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int unsigned DEPTH = HEAP_DEPTH
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = AW + 2;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UP_RD  = 3'd1;
  localparam logic [2:0] S_UP_CMP = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_DN_RD  = 3'd4;
  localparam logic [2:0] S_DN_CMP = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] idx_q, idx_d;
  entry_t        cur_q, cur_d;
  logic          peek_q, peek_d;
  logic [1:0]    res_status_q, res_status_d;
  entry_t        res_entry_q, res_entry_d;
  out_t          out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [AW-1:0] ram_raddr0;
  logic [AW-1:0] ram_raddr1;
  entry_t        ram_rdata0;
  entry_t        ram_rdata1;

  logic [XW-1:0] left_x;
  logic [XW-1:0] right_x;
  logic [XW-1:0] count_x;
  logic [AW-1:0] parent;
  logic          left_ok;
  logic          right_ok;
  logic          cur_ge_left;
  logic          cur_ge_right;
  logic          left_wins;

  bmhq_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr0_i (ram_raddr0),
    .raddr1_i (ram_raddr1),
    .rdata0_o (ram_rdata0),
    .rdata1_o (ram_rdata1)
  );

  // child and parent positions of the hole
  assign left_x  = (XW'(idx_q) << 1) + XW'(1);
  assign right_x = left_x + XW'(1);
  assign count_x = XW'(count_q);
  assign parent  = AW'((idx_q - AW'(1)) >> 1);

  // shared compare unit; a missing child ranks below every key
  assign left_ok      = left_x < count_x;
  assign right_ok     = right_x < count_x;
  assign cur_ge_left  = !left_ok || (cur_q.key >= ram_rdata0.key);
  assign cur_ge_right = !right_ok || (cur_q.key >= ram_rdata1.key);
  assign left_wins    = left_ok && (!right_ok || (ram_rdata0.key > ram_rdata1.key));

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    peek_d       = peek_q;
    res_status_d = res_status_q;
    res_entry_d  = res_entry_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = cur_q;
    ram_raddr0   = '0;
    ram_raddr1   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_status_d = ST_OK;
          res_entry_d  = '0;
          unique case (in_data_i.mode)
            MODE_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
                state_d      = S_FIN;
              end else begin
                cur_d   = '{key: in_data_i.item_key, tag: in_data_i.item_tag};
                idx_d   = AW'(count_q);
                count_d = count_q + CW'(1);
                state_d = S_UP_RD;
              end
            end
            MODE_POP, MODE_PEEK: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                state_d      = S_FIN;
              end else begin
                ram_raddr0 = '0;
                ram_raddr1 = AW'(count_q - CW'(1));
                peek_d     = in_data_i.mode == MODE_PEEK;
                if (in_data_i.mode == MODE_POP) begin
                  count_d = count_q - CW'(1);
                end
                state_d = S_ROOT;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
              state_d = S_FIN;
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_UP_RD: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          state_d = S_FIN;
        end else begin
          ram_raddr0 = parent;
          state_d    = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (ram_rdata0.key < cur_q.key) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata0;
          idx_d     = parent;
          state_d   = S_UP_RD;
        end else begin
          state_d = S_FIN;
        end
      end
      S_ROOT: begin
        res_entry_d = ram_rdata0;
        if (peek_q || count_q == '0) begin
          state_d = S_FIN;
        end else begin
          // last entry fills the root hole and sinks
          cur_d   = ram_rdata1;
          idx_d   = '0;
          state_d = S_DN_RD;
        end
      end
      S_DN_RD: begin
        ram_raddr0 = AW'(left_x);
        ram_raddr1 = AW'(right_x);
        state_d    = S_DN_CMP;
      end
      S_DN_CMP: begin
        ram_we = 1'b1;
        if (cur_ge_left && cur_ge_right) begin
          state_d = S_FIN;
        end else if (left_wins) begin
          ram_wdata = ram_rdata0;
          idx_d     = AW'(left_x);
          state_d   = S_DN_RD;
        end else begin
          // equal children go right
          ram_wdata = ram_rdata1;
          idx_d     = AW'(right_x);
          state_d   = S_DN_RD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d = '{status:      res_status_q,
                    out_key:     res_entry_q.key,
                    out_tag:     res_entry_q.tag,
                    entry_count: COUNT_W'(count_q)};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cur_q        <= cur_d;
    peek_q       <= peek_d;
    res_status_q <= res_status_d;
    res_entry_q  <= res_entry_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
